// ===== rtl/lpmf_pkg.sv =====
// Package for the length-prefixed message FIFO.
// Holds sizes, opcode and status codes, and the command and write-port structs.
// No dependencies.
`default_nettype none

package lpmf_pkg;

  // Storage geometry
  localparam int SLOTS         = 16;
  localparam int MAX_MSG_BYTES = 64;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int IDX_W         = $clog2(MAX_MSG_BYTES);
  localparam int ADDR_W        = SLOT_W + IDX_W;
  localparam int CNT_W         = $clog2(SLOTS + 1);

  // Field and register widths
  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int ST_W      = 2;
  localparam int LEN_W     = 7;
  localparam int FILL_W    = 7;
  localparam int CFG_SLOT_W  = 5;
  localparam int CFG_BYTES_W = 7;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_IDX_W   = 1;

  // Command queue between front and back
  localparam int CMDQ_DEPTH   = 4;
  localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);
  localparam int STREAM_CNT_W = $clog2(CMDQ_DEPTH + 2);

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'd1;

  // One unit of work for the back end: a status result or a message stream
  typedef struct packed {
    logic              is_stream;
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // Message store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ===== rtl/lpmf_if.sv =====
// Valid/ready channel interfaces for the message FIFO input and result streams.
// Depends on lpmf_pkg for field widths.
`default_nettype none

interface lpmf_in_if import lpmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_last;

  modport source (output valid, output opcode, output data_byte, output byte_last,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input byte_last,
                output ready);
endinterface

interface lpmf_out_if import lpmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [BYTE_W-1:0] read_byte;
  logic [LEN_W-1:0]  msg_length;
  logic              result_last;

  modport source (output valid, output status, output read_byte, output msg_length,
                  output result_last, input ready);
  modport sink (input valid, input status, input read_byte, input msg_length,
                input result_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/length_prefixed_message_fifo.sv =====
// Length-prefixed message FIFO, top level: front end, command queue, back end.
// Depends on lpmf_pkg, lpmf_if, lpmf_front, lpmf_cmd_queue and lpmf_back.
//
// A circular queue of 16 slots of up to 64 bytes each. A push byte is taken every
// cycle while ready is high; the end-marked byte yields one status transaction. A
// pop or peek yields one transaction per message byte, one per cycle while the
// result channel takes them, the first passing the command queue, read stage and
// output register; on an empty FIFO it yields one status transaction. Commands
// pass through a four-entry queue, so input keeps flowing while results drain
// until that queue fills. A push byte is held off while any taken pop or peek is
// still reading from the message store (one write and one read port), and longer
// while the result channel holds off. Configuration writes are registered.
`default_nettype none

module length_prefixed_message_fifo import lpmf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  lpmf_in_if.sink                    in_ch,
  lpmf_out_if.source                 out_ch
);

  logic    cmd_push;
  cmd_t    cmd_in;
  logic    cmd_space;
  logic    cmd_pop;
  logic    head_valid;
  cmd_t    head_cmd;
  logic    stream_done;
  mem_wr_t mem_wr;

  // Accept and classify input
  lpmf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .cmd_push    (cmd_push),
    .cmd_out     (cmd_in),
    .cmd_space   (cmd_space),
    .stream_done (stream_done),
    .mem_wr      (mem_wr)
  );

  // Decouple front and back
  lpmf_cmd_queue u_cmd_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (cmd_in),
    .space      (cmd_space),
    .pop        (cmd_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Execute commands and drive results
  lpmf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mem_wr      (mem_wr),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .cmd_pop     (cmd_pop),
    .stream_done (stream_done),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/lpmf_cmd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on lpmf_pkg for cmd_t and the queue depth.
`default_nettype none

module lpmf_cmd_queue import lpmf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      space,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t                  entry_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] count_r;

  assign space      = (count_r != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  // Hold entries; no reset needed on payload
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lpmf_front.sv =====
// Front end: takes input transactions, holds configuration and queue bookkeeping,
// writes message bytes and lengths, and issues commands. Depends on lpmf_pkg.
`default_nettype none

module lpmf_front import lpmf_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  lpmf_in_if.sink                     in_ch,
  output logic                        cmd_push,
  output cmd_t                        cmd_out,
  input  wire logic                   cmd_space,
  input  wire logic                   stream_done,
  output mem_wr_t                     mem_wr
);

  localparam logic [FILL_W-1:0] FILL_MAX = '1;

  logic [CFG_SLOT_W-1:0]   slot_count_r;
  logic [CFG_BYTES_W-1:0]  slot_bytes_r;
  logic [SLOT_W-1:0]       wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0]       rd_slot_r, rd_slot_nxt;
  logic [CNT_W-1:0]        msg_cnt_r, msg_cnt_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic                    rejected_r, rejected_nxt;
  logic [STREAM_CNT_W-1:0] stream_cnt_r;
  logic [LEN_W-1:0]        len_mem_r [SLOTS];

  logic [CNT_W-1:0]        eff_slots;
  logic [LEN_W-1:0]        eff_bytes;
  logic                    full;
  logic                    accept;
  logic                    len_we;
  logic [FILL_W-1:0]       fill_inc;
  logic [CNT_W-1:0]        wr_slot_inc;
  logic [CNT_W-1:0]        rd_slot_inc;

  // Clamp configuration into its legal range
  always_comb begin
    if (slot_count_r == '0) begin
      eff_slots = CNT_W'(1);
    end else if (CNT_W'(slot_count_r) > CNT_W'(SLOTS)) begin
      eff_slots = CNT_W'(SLOTS);
    end else begin
      eff_slots = CNT_W'(slot_count_r);
    end
    if (slot_bytes_r == '0) begin
      eff_bytes = LEN_W'(1);
    end else if (slot_bytes_r > CFG_BYTES_W'(MAX_MSG_BYTES)) begin
      eff_bytes = LEN_W'(MAX_MSG_BYTES);
    end else begin
      eff_bytes = slot_bytes_r;
    end
  end

  assign full = (msg_cnt_r >= eff_slots);

  // Stall pushes while a stream may still read a slot that a push could reuse
  assign in_ch.ready = cmd_space && !(in_ch.opcode == OP_PUSH && stream_cnt_r != '0);
  assign accept      = in_ch.valid && in_ch.ready;

  assign fill_inc    = (fill_r != FILL_MAX) ? fill_r + 1'b1 : fill_r;
  assign wr_slot_inc = CNT_W'(wr_slot_r) + 1'b1;
  assign rd_slot_inc = CNT_W'(rd_slot_r) + 1'b1;

  // Classify the transaction and update bookkeeping
  always_comb begin
    wr_slot_nxt  = wr_slot_r;
    rd_slot_nxt  = rd_slot_r;
    msg_cnt_nxt  = msg_cnt_r;
    fill_nxt     = fill_r;
    rejected_nxt = rejected_r;
    len_we       = 1'b0;
    cmd_push     = 1'b0;
    cmd_out      = '0;
    mem_wr       = '0;
    mem_wr.addr  = {wr_slot_r, fill_r[IDX_W-1:0]};
    mem_wr.data  = in_ch.data_byte;
    cmd_out.slot = rd_slot_r;
    cmd_out.len  = len_mem_r[rd_slot_r];
    if (accept) begin
      case (in_ch.opcode) inside
        OP_PUSH: begin
          if (LEN_W'(fill_r) < eff_bytes) begin
            if (full) begin
              rejected_nxt = 1'b1;
            end else begin
              mem_wr.en = 1'b1;
            end
          end
          fill_nxt = fill_inc;
          if (in_ch.byte_last) begin
            cmd_push = 1'b1;
            if (LEN_W'(fill_inc) > eff_bytes) begin
              cmd_out.status = ST_INVALID;
            end else if (full || rejected_r) begin
              cmd_out.status = ST_FULL;
            end else begin
              cmd_out.status = ST_OK;
              len_we         = 1'b1;
              wr_slot_nxt    = (wr_slot_inc >= eff_slots) ? '0 : wr_slot_inc[SLOT_W-1:0];
              msg_cnt_nxt    = msg_cnt_r + 1'b1;
            end
            fill_nxt     = '0;
            rejected_nxt = 1'b0;
          end
        end
        OP_POP, OP_PEEK: begin
          cmd_push = 1'b1;
          if (msg_cnt_r == '0) begin
            cmd_out.status = ST_EMPTY;
          end else begin
            cmd_out.is_stream = 1'b1;
            cmd_out.status    = ST_OK;
            if (in_ch.opcode == OP_POP) begin
              rd_slot_nxt = (rd_slot_inc >= eff_slots) ? '0 : rd_slot_inc[SLOT_W-1:0];
              msg_cnt_nxt = msg_cnt_r - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Store committed lengths
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem_r[wr_slot_r] <= fill_inc;
    end
  end

  // Hold configuration, pointers and stream count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= CFG_SLOT_W'(SLOTS);
      slot_bytes_r <= CFG_BYTES_W'(MAX_MSG_BYTES);
      wr_slot_r    <= '0;
      rd_slot_r    <= '0;
      msg_cnt_r    <= '0;
      fill_r       <= '0;
      rejected_r   <= 1'b0;
      stream_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLOT_COUNT: slot_count_r <= cfg_wdata[CFG_SLOT_W-1:0];
          CFG_SLOT_BYTES: slot_bytes_r <= cfg_wdata[CFG_BYTES_W-1:0];
          default: begin
          end
        endcase
      end
      wr_slot_r  <= wr_slot_nxt;
      rd_slot_r  <= rd_slot_nxt;
      msg_cnt_r  <= msg_cnt_nxt;
      fill_r     <= fill_nxt;
      rejected_r <= rejected_nxt;
      if ((cmd_push && cmd_out.is_stream) && !stream_done) begin
        stream_cnt_r <= stream_cnt_r + 1'b1;
      end else if (!(cmd_push && cmd_out.is_stream) && stream_done) begin
        stream_cnt_r <= stream_cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lpmf_back.sv =====
// Back end: holds the message store, runs commands from the queue, and streams
// message bytes or status results into the output register. Depends on lpmf_pkg.
`default_nettype none

module lpmf_back import lpmf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire mem_wr_t mem_wr,
  input  wire logic    head_valid,
  input  wire cmd_t    head_cmd,
  output logic         cmd_pop,
  output logic         stream_done,
  lpmf_out_if.source   out_ch
);

  logic [BYTE_W-1:0] msg_mem [SLOTS * MAX_MSG_BYTES];

  // Current stream
  logic              busy_r;
  logic [SLOT_W-1:0] slot_r;
  logic [LEN_W-1:0]  len_r;
  logic [IDX_W-1:0]  idx_r;

  // Read stage
  logic              s1_valid_r;
  logic              s1_stream_r;
  logic [ST_W-1:0]   s1_status_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic              s1_last_r;
  logic [BYTE_W-1:0] rd_data_r;

  // Output register
  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_last_r;

  logic              adv;
  logic              sel_valid;
  logic              sel_stream;
  logic [ST_W-1:0]   sel_status;
  logic [SLOT_W-1:0] sel_slot;
  logic [LEN_W-1:0]  sel_len;
  logic [IDX_W-1:0]  sel_idx;
  logic              sel_last;
  logic              issue_rd;

  assign adv = !out_valid_r || out_ch.ready;

  // Pick the running stream, else the queue head
  always_comb begin
    if (busy_r) begin
      sel_valid  = 1'b1;
      sel_stream = 1'b1;
      sel_status = ST_OK;
      sel_slot   = slot_r;
      sel_len    = len_r;
      sel_idx    = idx_r;
    end else begin
      sel_valid  = head_valid;
      sel_stream = head_cmd.is_stream;
      sel_status = head_cmd.status;
      sel_slot   = head_cmd.slot;
      sel_len    = head_cmd.len;
      sel_idx    = '0;
    end
    sel_last = !sel_stream || ((LEN_W'(sel_idx) + 1'b1) == sel_len);
  end

  assign issue_rd    = adv && sel_valid && sel_stream;
  assign cmd_pop     = adv && !busy_r && head_valid;
  assign stream_done = issue_rd && sel_last;

  // Message store: one write port from the front, one registered read port
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      msg_mem[mem_wr.addr] <= mem_wr.data;
    end
    if (issue_rd) begin
      rd_data_r <= msg_mem[{sel_slot, sel_idx}];
    end
  end

  // Advance stream state, read stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      s1_valid_r  <= sel_valid;
      if (issue_rd) begin
        busy_r <= !sel_last;
        slot_r <= sel_slot;
        len_r  <= sel_len;
        idx_r  <= sel_idx + 1'b1;
      end
    end
  end

  // Payload of the read stage and output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= s1_status_r;
      out_byte_r   <= s1_stream_r ? rd_data_r : '0;
      out_len_r    <= s1_stream_r ? s1_len_r : '0;
      out_last_r   <= s1_last_r;
      s1_stream_r  <= sel_stream;
      s1_status_r  <= sel_status;
      s1_len_r     <= sel_len;
      s1_last_r    <= sel_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.read_byte   = out_byte_r;
  assign out_ch.msg_length  = out_len_r;
  assign out_ch.result_last = out_last_r;

endmodule

`default_nettype wire
